// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/mcspg_pkg.sv =====
// package for the multi channel servo pulse generator: codes, widths, constants
package mcspg_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int WIDTH_W      = 14;
   localparam int TICK_W       = 16;
   localparam int PIN_W        = 4;

   localparam logic [15:0] FRAME_TICKS_RESET  = 16'd12500;
   localparam logic [15:0] MIN_PULSE_US_RESET = 16'd1000;

   // angle * 25 / 9 computed as (angle * 25 * 7282) >> 16, exact for 8-bit angles
   localparam logic [17:0] ANGLE_SCALE       = 18'd182050;
   localparam int          ANGLE_SCALE_SHIFT = 16;

   typedef enum logic [1:0] {
      REQ_TICK        = 2'd0,
      REQ_WRITE_US    = 2'd1,
      REQ_WRITE_ANGLE = 2'd2,
      REQ_NONE        = 2'd3
   } req_kind_type;

   typedef enum logic {
      CSR_FRAME_TICKS  = 1'b0,
      CSR_MIN_PULSE_US = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/core/multi_channel_servo_pulse_generator_unit.sv =====
// servo pulse generator top level: request register, per-channel compare, response register
//
//  channel | handshake          | payload
//  req     | req_valid/req_stall| req_req_type, req_channel, req_pulse_us, req_angle_deg
//  rsp     | rsp_valid/rsp_stall| rsp_pin_levels, rsp_frame_start, rsp_write_accepted
//  csr     | csr_valid/csr_ready| csr_index, csr_data
//
// every beat passes from acceptance to response through the request register, then
// the response register; one beat is accepted per cycle unless req_stall is high; the
// single compare stage updates all channels in parallel. synchronous active-high reset clears
// widths, tick count and pins and loads the default frame length and minimum pulse.
// rsp_stall holds the response register; req_stall rises only while a beat waits
// in the request register behind a held response. csr writes are always ready.
`include "assert_macros.svh"

module multi_channel_servo_pulse_generator_unit
   import mcspg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_req_type,
   input  logic [3:0]  req_channel,
   input  logic [15:0] req_pulse_us,
   input  logic [7:0]  req_angle_deg,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_pin_levels,
   output logic        rsp_frame_start,
   output logic        rsp_write_accepted,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   // request stage
   logic               s1_valid_ff, s1_valid_in;
   req_kind_type       s1_kind_ff;
   logic [3:0]         s1_channel_ff;
   logic [15:0]        s1_pulse_us_ff;
   logic [7:0]         s1_angle_ff;

   // response stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIN_W-1:0]   rsp_pins_ff, rsp_pins_in;
   logic               rsp_fstart_ff, rsp_fstart_in;
   logic               rsp_accepted_ff, rsp_accepted_in;

   // configuration
   logic [15:0]        frame_ticks_ff;
   logic [15:0]        min_pulse_us_ff;

   // servo state
   logic [WIDTH_W-1:0] active_width_ff  [NUM_CHANNELS];
   logic [WIDTH_W-1:0] active_width_in  [NUM_CHANNELS];
   logic [WIDTH_W-1:0] pending_width_ff [NUM_CHANNELS];
   logic [WIDTH_W-1:0] pending_width_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] pending_valid_ff, pending_valid_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [PIN_W-1:0]   pin_state_ff, pin_state_in;

   // handshake
   logic               out_free;
   logic               s1_fire;
   logic               req_fire;

   // datapath helpers
   logic [25:0]        angle_product;
   logic [9:0]         angle_quot;
   logic [15:0]        angle_us;
   logic [15:0]        write_us;
   logic [WIDTH_W-1:0] write_width;
   logic               chan_hit;
   logic [CH_IDX_W-1:0] chan_idx;
   logic [15:0]        frame_len;
   logic [TICK_W:0]    tick_next;
   logic               frame_begin;
   logic [NUM_CHANNELS-1:0] pin_cmp;

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_kind_ff     <= req_kind_type'(req_req_type);
         s1_channel_ff  <= req_channel;
         s1_pulse_us_ff <= req_pulse_us;
         s1_angle_ff    <= req_angle_deg;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ticks_ff  <= FRAME_TICKS_RESET;
         min_pulse_us_ff <= MIN_PULSE_US_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_TICKS:  frame_ticks_ff  <= csr_data;
            CSR_MIN_PULSE_US: min_pulse_us_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // width from microseconds or from angle
   assign angle_product = 26'(s1_angle_ff) * 26'(ANGLE_SCALE);
   assign angle_quot    = angle_product[ANGLE_SCALE_SHIFT +: 10];
   assign angle_us      = min_pulse_us_ff + {4'd0, angle_quot, 2'b00};
   assign write_us      = (s1_kind_ff == REQ_WRITE_ANGLE) ? angle_us : s1_pulse_us_ff;
   assign write_width   = write_us[15:2];

   // channel decode, servo numbers start at one
   assign chan_hit = (s1_channel_ff != 4'd0) && (32'(s1_channel_ff) <= NUM_CHANNELS);
   assign chan_idx = CH_IDX_W'(s1_channel_ff - 4'd1);

   // frame counter
   assign frame_len   = (frame_ticks_ff == 16'd0) ? 16'd1 : frame_ticks_ff;
   assign frame_begin = (tick_count_ff == '0);
   assign tick_next   = {1'b0, tick_count_ff} + 17'd1;

   // per-channel compare against the width in force for this tick
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (frame_begin && pending_valid_ff[k]) begin
            pin_cmp[k] = {2'b00, pending_width_ff[k]} > tick_count_ff;
         end else begin
            pin_cmp[k] = {2'b00, active_width_ff[k]} > tick_count_ff;
         end
      end
   end

   // state update and response for the beat in the request register
   always_comb begin
      active_width_in  = active_width_ff;
      pending_width_in = pending_width_ff;
      pending_valid_in = pending_valid_ff;
      tick_count_in    = tick_count_ff;
      pin_state_in     = pin_state_ff;
      rsp_fstart_in    = 1'b0;
      rsp_accepted_in  = 1'b0;
      if (s1_fire) begin
         case (s1_kind_ff)
            REQ_TICK: begin
               rsp_fstart_in = frame_begin;
               if (frame_begin) begin
                  for (int k = 0; k < NUM_CHANNELS; k++) begin
                     if (pending_valid_ff[k]) begin
                        active_width_in[k] = pending_width_ff[k];
                     end
                  end
                  pending_valid_in = '0;
               end
               pin_state_in = '0;
               for (int k = 0; k < NUM_CHANNELS && k < PIN_W; k++) begin
                  pin_state_in[k] = pin_cmp[k];
               end
               tick_count_in = (tick_next >= {1'b0, frame_len}) ? '0 : tick_next[TICK_W-1:0];
            end
            REQ_WRITE_US, REQ_WRITE_ANGLE: begin
               if (chan_hit) begin
                  pending_width_in[chan_idx] = write_width;
                  pending_valid_in[chan_idx] = 1'b1;
                  rsp_accepted_in            = 1'b1;
               end
            end
            default: ;
         endcase
      end
      rsp_pins_in = pin_state_in;
   end

   // servo state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            active_width_ff[k]  <= '0;
            pending_width_ff[k] <= '0;
         end
         pending_valid_ff <= '0;
         tick_count_ff    <= '0;
         pin_state_ff     <= '0;
      end else begin
         active_width_ff  <= active_width_in;
         pending_width_ff <= pending_width_in;
         pending_valid_ff <= pending_valid_in;
         tick_count_ff    <= tick_count_in;
         pin_state_ff     <= pin_state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire) begin
         rsp_pins_ff     <= rsp_pins_in;
         rsp_fstart_ff   <= rsp_fstart_in;
         rsp_accepted_ff <= rsp_accepted_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pin_levels     = rsp_pins_ff;
   assign rsp_frame_start    = rsp_fstart_ff;
   assign rsp_write_accepted = rsp_accepted_ff;

   // checks
   `ASSERT_ALWAYS(a_stall_only_when_held, clock, reset, !req_stall || s1_valid_ff)
   `ASSERT_NEXT(a_held_beat_stable, clock, reset, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_pulse_us_ff) && $stable(s1_channel_ff))
   `ASSERT_ALWAYS(a_flags_exclusive, clock, reset, !(rsp_valid_ff && rsp_fstart_ff && rsp_accepted_ff))
   `ASSERT_NEXT(a_frame_start_drains_pending, clock, reset, s1_fire && s1_kind_ff == REQ_TICK && frame_begin, pending_valid_ff == '0)

endmodule
